>>> design/mmpq_pkg.sv
// Shared types and constants for the mouse motion packet queue.
// No dependencies; the front end, back end and top level import this package.
package mmpq_pkg;

  localparam int FIFO_DEPTH_DEF = 160;

  // Command codes carried on the input tuser
  localparam logic [2:0] CMD_MOVE     = 3'd0;
  localparam logic [2:0] CMD_BTN_DOWN = 3'd1;
  localparam logic [2:0] CMD_BTN_UP   = 3'd2;
  localparam logic [2:0] CMD_SEND     = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MOVE,
    OP_BTN_SET,
    OP_BTN_CLR,
    OP_SEND,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [2:0]  btn_mask;
  } cmd_rec_t;

  typedef struct packed {
    logic [7:0] fifo_level;
    logic [5:0] packets_queued;
    logic [7:0] read_data;
  } res_t;

  // Clamp a 16-bit two's complement value to -256..255 (9-bit result)
  function automatic logic [8:0] clamp_delta(input logic [15:0] v);
    logic [8:0] r;
    r = v[8:0];
    if (!v[15] && (v > 16'h00FF)) begin
      r = 9'h0FF;
    end else if (v[15] && (v < 16'hFF00)) begin
      r = 9'h100;
    end
    return r;
  endfunction

endpackage

>>> design/mouse_motion_packet_queue_unit.sv
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tuser: cmd; tdata: move_dx, move_dy, button_index
// out_     out  out_tvalid/out_tready  tdata: read_data, packets_queued, fifo_level
//
// Move, button and unknown commands load the result in ST_IDLE; a read passes
// ST_READ (registered RAM read port); a send writes each packet byte by byte in
// ST_PKT, ST_B1, ST_B2 via the single RAM write port, ending early if the FIFO fills.
// Reset (rst_n, synchronous, active low) clears accumulators, buttons and the
// FIFO pointers; FIFO contents are not cleared. A two-entry command queue lets
// the input keep accepting while the back end works or the output stalls.
// Top level: wires the front end and the back end, which holds the packet RAM.
// Depends on mmpq_pkg, mmpq_front and mmpq_back.
module mouse_motion_packet_queue_unit #(
  parameter int FIFO_DEPTH = mmpq_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [15:0] move_dx, [31:16] move_dy, [33:32] button_index, [39:34] zero
  input  logic [mmpq_pkg::IN_DATA_W-1:0]       in_tdata,
  // [2:0] cmd
  input  logic [mmpq_pkg::IN_USER_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [7:0] read_data, [13:8] packets_queued, [21:14] fifo_level, [23:22] zero
  output logic [mmpq_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import mmpq_pkg::*;

  logic     q_valid;
  logic     q_pop;
  cmd_rec_t q_cmd;

  mmpq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd)
  );

  mmpq_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> design/mmpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/mmpq_front.sv
// Front end: accepts stream items, decodes the command, and holds them in a
// two-entry queue for the back end. Depends on mmpq_pkg.
module mmpq_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mmpq_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [mmpq_pkg::IN_USER_W-1:0]       in_tuser,
  output logic                                 q_valid,
  input  logic                                 q_pop,
  output mmpq_pkg::cmd_rec_t                   q_cmd
);
  import mmpq_pkg::*;

  cmd_rec_t   dec;
  cmd_rec_t   q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  always_comb begin
    dec.dx = in_tdata[15:0];
    dec.dy = in_tdata[31:16];
    unique case (in_tdata[33:32])
      2'd0:    dec.btn_mask = 3'b001;
      2'd1:    dec.btn_mask = 3'b010;
      2'd2:    dec.btn_mask = 3'b100;
      default: dec.btn_mask = 3'b000;
    endcase
    unique case (in_tuser)
      CMD_MOVE:     dec.op = OP_MOVE;
      CMD_BTN_DOWN: dec.op = OP_BTN_SET;
      CMD_BTN_UP:   dec.op = OP_BTN_CLR;
      CMD_SEND:     dec.op = OP_SEND;
      CMD_READ:     dec.op = OP_READ;
      default:      dec.op = OP_NOP;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> design/mmpq_back.sv
// Back end: motion accumulators, button bits, packet builder and byte FIFO
// control, plus the result register. Depends on mmpq_pkg and mmpq_ram.
module mmpq_back #(
  parameter int FIFO_DEPTH = mmpq_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  output logic                                 q_pop,
  input  mmpq_pkg::cmd_rec_t                   q_cmd,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mmpq_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import mmpq_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PKT  = 6'b000010,
    ST_B1   = 6'b000100,
    ST_B2   = 6'b001000,
    ST_READ = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [2:0]  btn_r, btn_nxt;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [8:0]  sx_r, sx_nxt, sy_r, sy_nxt;
  logic [5:0]  pq_r, pq_nxt;
  logic        hit_r, hit_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        res_r, res_nxt;
  logic        load;
  res_t        load_res;

  logic        ram_we;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;

  logic [16:0] sum_x, sum_y;
  logic [15:0] rem_x, rem_y;
  logic [8:0]  cx, cy;
  logic        slot_free;

  mmpq_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  function automatic logic [7:0] level8(input logic [CW-1:0] c);
    return (32'(c) > 32'd255) ? 8'hFF : 8'(c);
  endfunction

  function automatic logic [15:0] sat16(input logic [16:0] s);
    logic [15:0] r;
    r = s[15:0];
    if (s[16] != s[15]) begin
      r = s[16] ? 16'h8000 : 16'h7FFF;
    end
    return r;
  endfunction

  assign slot_free = !out_valid_r || out_tready;
  assign q_pop     = (state_r == ST_IDLE) && q_valid && slot_free;

  assign sum_x = {ax_r[15], ax_r} + {q_cmd.dx[15], q_cmd.dx};
  assign sum_y = {ay_r[15], ay_r} - {q_cmd.dy[15], q_cmd.dy};
  assign cx    = clamp_delta(ax_r);
  assign cy    = clamp_delta(ay_r);
  assign rem_x = ax_r - {{7{sx_r[8]}}, sx_r};
  assign rem_y = ay_r - {{7{sy_r[8]}}, sy_r};

  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    btn_nxt   = btn_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    pq_nxt    = pq_r;
    hit_nxt   = hit_r;
    ram_we    = 1'b0;
    ram_wdata = 8'h00;
    load      = 1'b0;
    load_res  = '0;
    load_res.fifo_level = level8(cnt_r);

    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_cmd.op)
            OP_MOVE: begin
              ax_nxt = sat16(sum_x);
              ay_nxt = sat16(sum_y);
              load   = 1'b1;
            end
            OP_BTN_SET: begin
              btn_nxt = btn_r | q_cmd.btn_mask;
              load    = 1'b1;
            end
            OP_BTN_CLR: begin
              btn_nxt = btn_r & ~q_cmd.btn_mask;
              load    = 1'b1;
            end
            OP_SEND: begin
              pq_nxt    = 6'd0;
              state_nxt = ST_PKT;
            end
            OP_READ: begin
              // RAM read at head is issued this cycle
              hit_nxt = (cnt_r != '0);
              if (cnt_r != '0) begin
                head_nxt = (head_r == AW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
                cnt_nxt  = cnt_r - 1'b1;
              end
              state_nxt = ST_READ;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_PKT: begin
        if (cnt_r > CW'(FIFO_DEPTH - 3)) begin
          state_nxt = ST_DONE;
        end else begin
          sx_nxt    = cx;
          sy_nxt    = cy;
          ram_we    = 1'b1;
          ram_wdata = {2'b00, cy[8], cx[8], 1'b1, btn_r};
          tail_nxt  = (tail_r == AW'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_B1;
        end
      end
      ST_B1: begin
        ram_we    = 1'b1;
        ram_wdata = sx_r[7:0];
        tail_nxt  = (tail_r == AW'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_B2;
      end
      ST_B2: begin
        ram_we    = 1'b1;
        ram_wdata = sy_r[7:0];
        tail_nxt  = (tail_r == AW'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        ax_nxt    = rem_x;
        ay_nxt    = rem_y;
        pq_nxt    = (pq_r == 6'h3F) ? pq_r : pq_r + 6'd1;
        // repeat only while both remainders are nonzero
        state_nxt = ((rem_x != 16'h0000) && (rem_y != 16'h0000)) ? ST_PKT : ST_DONE;
      end
      ST_READ: begin
        load               = 1'b1;
        load_res.read_data = hit_r ? ram_rdata : 8'h00;
        state_nxt          = ST_IDLE;
      end
      ST_DONE: begin
        load                    = 1'b1;
        load_res.packets_queued = pq_r;
        state_nxt               = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    res_nxt       = res_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      res_nxt       = load_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 24'(res_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ax_r        <= 16'h0000;
      ay_r        <= 16'h0000;
      btn_r       <= 3'b000;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      ay_r        <= ay_nxt;
      btn_r       <= btn_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    pq_r  <= pq_nxt;
    hit_r <= hit_nxt;
    res_r <= res_nxt;
  end

endmodule
